// ===== rtl/owring_pkg.sv =====
// Shared constants, types and helpers for the overwriting ring with offset lookup.
// No dependencies; imported by the top level, owring_sub and owring_chk.
`timescale 1ns / 1ps

package owring_pkg;

  // Ring geometry
  localparam int SLOTS  = 16;
  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int WORD_W = 32;
  localparam int ENTRY_W = 2 * WORD_W;  // {ref, size}
  localparam int SLOT_OUT_W = 4;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_FIND,
    ST_DONE
  } state_e;

  // Input modes
  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_FIND = 1'b1;

  // Advance a slot index with wrap at the ring depth
  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] nxt;
    if (idx == IDX_W'(SLOTS - 1)) begin
      nxt = '0;
    end else begin
      nxt = idx + 1'b1;
    end
    return nxt;
  endfunction

endpackage

// ===== rtl/overwrite_ring_with_offset_lookup.sv =====
// Overwriting ring of entries (reference, byte size) with lookup by character offset.
// An add goes from acceptance to a presented result in three steps: accept, write/evict,
// result load. A find walks k held entries (1 to SLOTS) between accept and result load;
// a find on an empty ring goes from accept straight to result load. The walk reads
// one entry per cycle through the single read port of the entry RAM and feeds the
// subtract unit. The input side stalls while an item is in progress; a
// finished result waits in the output register without blocking the next transaction.
// If that register still holds a stalled result when the next item finishes, the item
// waits in its last cycle and the input stays stalled until the receiver takes one.
// Depends on owring_pkg, owring_ram, owring_sub.
`timescale 1ns / 1ps

module overwrite_ring_with_offset_lookup
  import owring_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  mode_i,
  input  logic [WORD_W-1:0]     entry_ref_i,
  input  logic [WORD_W-1:0]     entry_size_i,
  input  logic [WORD_W-1:0]     char_offset_i,
  // output channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  evicted_valid_o,
  output logic [WORD_W-1:0]     evicted_ref_o,
  output logic [WORD_W-1:0]     evicted_size_o,
  output logic                  found_o,
  output logic [SLOT_OUT_W-1:0] found_slot_o,
  output logic [WORD_W-1:0]     found_ref_o,
  output logic [WORD_W-1:0]     byte_offset_o
);

  typedef struct packed {
    logic                  evicted_valid;
    logic [WORD_W-1:0]     evicted_ref;
    logic [WORD_W-1:0]     evicted_size;
    logic                  found;
    logic [SLOT_OUT_W-1:0] found_slot;
    logic [WORD_W-1:0]     found_ref;
    logic [WORD_W-1:0]     byte_offset;
  } res_t;

  // Control state
  state_e           state_q, state_d;
  logic [IDX_W-1:0] wr_q, wr_d;
  logic [IDX_W-1:0] rd_q, rd_d;
  logic             full_q, full_d;
  logic             out_valid_q, out_valid_d;

  // Datapath registers
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [WORD_W-1:0] offs_q, offs_d;
  logic [WORD_W-1:0] add_ref_q, add_ref_d;
  logic [WORD_W-1:0] add_size_q, add_size_d;
  res_t              res_q, res_d;
  res_t              out_q, out_d;

  // RAM and subtract unit hookup
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [WORD_W-1:0]  rd_ref;
  logic [WORD_W-1:0]  rd_size;
  logic               sub_ge;
  logic [WORD_W-1:0]  sub_diff;

  logic             accept;
  logic             out_free;
  logic             walk_last;
  logic [CNT_W-1:0] held;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign rd_ref   = ram_rdata[ENTRY_W-1:WORD_W];
  assign rd_size  = ram_rdata[WORD_W-1:0];

  // Number of held entries
  always_comb begin
    if (full_q) begin
      held = CNT_W'(SLOTS);
    end else if (wr_q >= rd_q) begin
      held = CNT_W'(wr_q) - CNT_W'(rd_q);
    end else begin
      held = CNT_W'(wr_q) + CNT_W'(SLOTS) - CNT_W'(rd_q);
    end
  end

  assign walk_last = ((cnt_q + 1'b1) == held);

  owring_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  owring_sub u_sub (
    .minuend_i   (offs_q),
    .subtrahend_i(rd_size),
    .ge_o        (sub_ge),
    .diff_o      (sub_diff)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (mode_i == MODE_ADD) begin
            state_d = ST_ADD;
          end else if (held == '0) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_FIND;
          end
        end
      end
      ST_ADD: state_d = ST_DONE;
      ST_FIND: begin
        if (!sub_ge || walk_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    wr_d       = wr_q;
    rd_d       = rd_q;
    full_d     = full_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    offs_d     = offs_q;
    add_ref_d  = add_ref_q;
    add_size_d = add_size_q;
    res_d      = res_q;
    ram_we     = 1'b0;
    ram_waddr  = wr_q;
    ram_wdata  = {add_ref_q, add_size_q};
    ram_raddr  = rd_q;
    unique case (state_q)
      ST_IDLE: begin
        // read of the oldest entry is issued here for both modes
        if (accept) begin
          add_ref_d  = entry_ref_i;
          add_size_d = entry_size_i;
          offs_d     = char_offset_i;
          idx_d      = rd_q;
          cnt_d      = '0;
          res_d      = '0;
        end
      end
      ST_ADD: begin
        ram_we = 1'b1;
        res_d  = '0;
        if (full_q) begin
          res_d.evicted_valid = 1'b1;
          res_d.evicted_ref   = rd_ref;
          res_d.evicted_size  = rd_size;
          rd_d = next_slot(rd_q);
        end
        wr_d   = next_slot(wr_q);
        full_d = (next_slot(wr_q) == rd_d);
      end
      ST_FIND: begin
        ram_raddr = next_slot(idx_q);
        res_d     = '0;
        if (sub_ge) begin
          offs_d = sub_diff;
          cnt_d  = cnt_q + 1'b1;
          idx_d  = next_slot(idx_q);
        end else begin
          res_d.found       = 1'b1;
          res_d.found_slot  = SLOT_OUT_W'(idx_q);
          res_d.found_ref   = rd_ref;
          res_d.byte_offset = offs_q;
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  // Output register
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if ((state_q == ST_DONE) && out_free) begin
      out_d       = res_q;
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wr_q        <= '0;
      rd_q        <= '0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_q        <= wr_d;
      rd_q        <= rd_d;
      full_q      <= full_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    cnt_q      <= cnt_d;
    offs_q     <= offs_d;
    add_ref_q  <= add_ref_d;
    add_size_q <= add_size_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign evicted_valid_o = out_q.evicted_valid;
  assign evicted_ref_o   = out_q.evicted_ref;
  assign evicted_size_o  = out_q.evicted_size;
  assign found_o         = out_q.found;
  assign found_slot_o    = out_q.found_slot;
  assign found_ref_o     = out_q.found_ref;
  assign byte_offset_o   = out_q.byte_offset;

endmodule

// ===== rtl/owring_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module owring_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/owring_sub.sv =====
// Compare-and-subtract unit used by the offset walk.
// Depends on owring_pkg.
`timescale 1ns / 1ps

module owring_sub
  import owring_pkg::*;
(
  input  logic [WORD_W-1:0] minuend_i,
  input  logic [WORD_W-1:0] subtrahend_i,
  output logic              ge_o,
  output logic [WORD_W-1:0] diff_o
);

  logic [WORD_W:0] diff_wide;

  // One wide subtract; the borrow gives the compare
  assign diff_wide = {1'b0, minuend_i} - {1'b0, subtrahend_i};
  assign ge_o      = ~diff_wide[WORD_W];
  assign diff_o    = diff_wide[WORD_W-1:0];

endmodule

// ===== rtl/owring_chk.sv =====
// Port-level checker for the overwriting ring, bound to the top level.
// Depends on owring_pkg.
`timescale 1ns / 1ps

module owring_chk
  import owring_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  mode_i,
  input logic [WORD_W-1:0]     entry_ref_i,
  input logic [WORD_W-1:0]     entry_size_i,
  input logic [WORD_W-1:0]     char_offset_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic                  evicted_valid_o,
  input logic [WORD_W-1:0]     evicted_ref_o,
  input logic [WORD_W-1:0]     evicted_size_o,
  input logic                  found_o,
  input logic [SLOT_OUT_W-1:0] found_slot_o,
  input logic [WORD_W-1:0]     found_ref_o,
  input logic [WORD_W-1:0]     byte_offset_o
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result dropped while stalled");

  // Every accepted transaction keeps the input stalled the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after acceptance");

  // An add result and a find result never mix
  a_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(evicted_valid_o && found_o))
    else $error("eviction and find flagged together");

  // No eviction means zero eviction fields
  a_evict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !evicted_valid_o) |-> (evicted_ref_o == '0 && evicted_size_o == '0))
    else $error("eviction fields nonzero without eviction");

  // Not found means zero lookup fields
  a_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |->
      (found_slot_o == '0 && found_ref_o == '0 && byte_offset_o == '0))
    else $error("lookup fields nonzero without a hit");

endmodule

bind overwrite_ring_with_offset_lookup owring_chk u_owring_chk (.*);
